>>> src/mcrs_pkg.sv
// Shared types and constants for the multi-channel ramp scheduler.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package mcrs_pkg;

  // Field widths fixed by the item and result formats
  localparam int VALUE_W     = 16;
  localparam int CH_W        = 3;
  localparam int KIND_W      = 2;
  localparam int REQ_PCT_W   = 8;
  localparam int PCT_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Default channel count for the top-level parameter
  localparam int CHANNELS_DEF = 8;

  // Item kinds (the fourth code is ignored)
  localparam logic [KIND_W-1:0] KIND_CONFIG = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TARGET = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ABS_MAX     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ABS_MIN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_PCT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PCT     = 2'd3;

  // Configuration reset values
  localparam logic [VALUE_W-1:0] ABS_MAX_RST     = 16'd1900;
  localparam logic [VALUE_W-1:0] ABS_MIN_RST     = 16'd1100;
  localparam logic [PCT_W-1:0]   DEFAULT_PCT_RST = 7'd10;
  localparam logic [PCT_W-1:0]   MAX_PCT_RST     = 7'd100;

  // Step = span * pct / 100, done as a multiply by a scaled reciprocal.
  // Exact for every product below 2^23 (span 16 bits times pct 7 bits).
  localparam int PERCENT_BASE = 100;
  localparam int PROD_W       = VALUE_W + PCT_W;
  localparam int RECIP_SHIFT  = 30;
  localparam int RECIP_W      = 24;
  localparam int QUO_W        = VALUE_W + 1;
  localparam logic [RECIP_W-1:0] PCT_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(PERCENT_BASE) - 64'd1) / 64'(PERCENT_BASE));

  // Input item
  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [CH_W-1:0]      channel;
    logic [VALUE_W-1:0]   limit_high;
    logic [VALUE_W-1:0]   limit_low;
    logic [REQ_PCT_W-1:0] step_percent;
    logic [VALUE_W-1:0]   target;
  } item_t;

  // Result item
  typedef struct packed {
    logic [CH_W-1:0]    out_channel;
    logic [VALUE_W-1:0] out_value;
    logic               reached;
    logic               idle;
  } result_t;

  // Configuration register contents
  typedef struct packed {
    logic [VALUE_W-1:0] abs_max;
    logic [VALUE_W-1:0] abs_min;
    logic [PCT_W-1:0]   default_pct;
    logic [PCT_W-1:0]   max_pct;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic load;
    logic mul;
    logic div;
    logic finish;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic drop;
    logic is_config;
  } status_t;

endpackage

>>> src/mcrs_cfg.sv
// Configuration register file: global limits and step percent settings.
// Depends on mcrs_pkg.
`timescale 1ns / 1ps

module mcrs_cfg import mcrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  // Register writes, one index per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.abs_max     <= ABS_MAX_RST;
      cfg.abs_min     <= ABS_MIN_RST;
      cfg.default_pct <= DEFAULT_PCT_RST;
      cfg.max_pct     <= MAX_PCT_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_ABS_MAX:     cfg.abs_max     <= wr_data[VALUE_W-1:0];
        REG_ABS_MIN:     cfg.abs_min     <= wr_data[VALUE_W-1:0];
        REG_DEFAULT_PCT: cfg.default_pct <= wr_data[PCT_W-1:0];
        REG_MAX_PCT:     cfg.max_pct     <= wr_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> src/mcrs_dp.sv
// Datapath: per-channel state, service queue, step arithmetic, result register.
// Depends on mcrs_pkg; driven by commands from mcrs_ctrl.
`timescale 1ns / 1ps

module mcrs_dp import mcrs_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  input  cfg_t    cfg,
  input  item_t   item_in,
  output status_t status,
  output result_t result
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = $clog2(CHANNELS + 1);
  localparam int SUM_W = CNT_W + 1;

  // Captured item and working registers
  item_t              item;
  logic [IDX_W-1:0]   cur_ch;
  logic [VALUE_W-1:0] cur_v;
  logic [VALUE_W-1:0] cur_t;
  logic [VALUE_W-1:0] cur_s;
  logic               tick_idle;
  logic [VALUE_W-1:0] hi_c;
  logic [VALUE_W-1:0] lo_c;
  logic [PCT_W-1:0]   pct;
  logic [PROD_W-1:0]  prod;
  logic [QUO_W-1:0]   quo;

  // Channel records
  logic [VALUE_W-1:0] drive  [CHANNELS];
  logic [VALUE_W-1:0] tgt    [CHANNELS];
  logic [VALUE_W-1:0] cmax   [CHANNELS];
  logic [VALUE_W-1:0] cmin   [CHANNELS];
  logic [VALUE_W-1:0] step   [CHANNELS];

  // Service queue
  logic [IDX_W-1:0]   fifo   [CHANNELS];
  logic [CHANNELS-1:0] queued;
  logic [IDX_W-1:0]   head;
  logic [CNT_W-1:0]   count;

  // Combinational helpers
  logic [IDX_W-1:0]   item_idx;
  logic [IDX_W-1:0]   pick_ch;
  logic [VALUE_W-1:0] tgt_clamp;
  logic [VALUE_W-1:0] hi_sel;
  logic [VALUE_W-1:0] lo_sel;
  logic [PCT_W-1:0]   pct_sel;
  logic [VALUE_W-1:0] span;
  logic [PROD_W+RECIP_W-1:0] recip_prod;
  logic [VALUE_W-1:0] step_v;
  logic               done;
  logic [VALUE_W:0]   mid_sum;
  logic [VALUE_W-1:0] mid;
  logic [VALUE_W-1:0] step_sat;
  logic [SUM_W-1:0]   tail_sum;
  logic [SUM_W-1:0]   tail_wrap;
  logic [IDX_W-1:0]   tail;
  logic [IDX_W-1:0]   head_inc;
  logic               push;
  logic               pop;

  // Status for the controller
  assign status.is_config = (item.kind == KIND_CONFIG);
  assign status.drop = !((item.kind == KIND_CONFIG) || (item.kind == KIND_TARGET) ||
                         (item.kind == KIND_TICK)) ||
                       ((item.kind != KIND_TICK) && (32'(item.channel) >= CHANNELS));

  // Channel selection and load-stage clamps
  assign item_idx = IDX_W'(item.channel);
  assign pick_ch  = (item.kind == KIND_TICK) ? fifo[head] : item_idx;

  always_comb begin
    tgt_clamp = item.target;
    if (tgt_clamp > cmax[pick_ch]) tgt_clamp = cmax[pick_ch];
    if (tgt_clamp < cmin[pick_ch]) tgt_clamp = cmin[pick_ch];
  end

  assign hi_sel = (item.limit_high >= cfg.abs_max) ? cfg.abs_max : item.limit_high;
  assign lo_sel = (item.limit_low <= cfg.abs_min) ? cfg.abs_min : item.limit_low;

  always_comb begin
    if (item.step_percent >= REQ_PCT_W'(cfg.max_pct)) pct_sel = cfg.max_pct;
    else if (item.step_percent == '0)                  pct_sel = cfg.default_pct;
    else                                               pct_sel = item.step_percent[PCT_W-1:0];
  end

  // Step size arithmetic
  assign span       = (hi_c >= lo_c) ? (hi_c - lo_c) : '0;
  assign recip_prod = (PROD_W + RECIP_W)'(prod) * (PROD_W + RECIP_W)'(PCT_RECIP);
  assign step_sat   = quo[QUO_W-1] ? '1 : quo[VALUE_W-1:0];
  assign mid_sum    = (VALUE_W + 1)'(hi_c) + (VALUE_W + 1)'(lo_c);
  assign mid        = mid_sum[VALUE_W:1];

  // One step toward the target, snapping when closer than one step
  always_comb begin
    step_v = cur_v;
    if (cur_v < cur_t) begin
      step_v = ((cur_t - cur_v) < cur_s) ? cur_t : (cur_v + cur_s);
    end else if (cur_v > cur_t) begin
      step_v = ((cur_v - cur_t) < cur_s) ? cur_t : (cur_v - cur_s);
    end
  end
  assign done = (step_v == cur_t);

  // Queue pointers
  assign tail_sum  = SUM_W'(head) + SUM_W'(count);
  assign tail_wrap = (tail_sum >= SUM_W'(CHANNELS)) ? (tail_sum - SUM_W'(CHANNELS)) : tail_sum;
  assign tail      = tail_wrap[IDX_W-1:0];
  assign head_inc  = (head == IDX_W'(CHANNELS - 1)) ? '0 : (head + 1'b1);

  assign pop  = cmd.load && (item.kind == KIND_TICK) && (count != '0);
  assign push = cmd.finish && !done && !queued[cur_ch] && (count < CNT_W'(CHANNELS)) &&
                ((item.kind == KIND_TARGET) || ((item.kind == KIND_TICK) && !tick_idle));

  // Item capture and working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) item <= item_in;
    if (cmd.load) begin
      cur_ch    <= pick_ch;
      cur_v     <= drive[pick_ch];
      cur_s     <= step[pick_ch];
      cur_t     <= (item.kind == KIND_TICK) ? tgt[pick_ch] : tgt_clamp;
      tick_idle <= (count == '0);
      hi_c      <= hi_sel;
      lo_c      <= lo_sel;
      pct       <= pct_sel;
    end
    if (cmd.mul) prod <= PROD_W'(span) * PROD_W'(pct);
    if (cmd.div) quo  <= recip_prod[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
  end

  // Channel record writeback
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        drive[i] <= '0;
        tgt[i]   <= '0;
        cmax[i]  <= '0;
        cmin[i]  <= '0;
        step[i]  <= '0;
      end
    end else if (cmd.finish) begin
      case (item.kind)
        KIND_CONFIG: begin
          cmax[cur_ch]  <= hi_c;
          cmin[cur_ch]  <= lo_c;
          step[cur_ch]  <= step_sat;
          drive[cur_ch] <= mid;
          tgt[cur_ch]   <= mid;
        end
        KIND_TARGET: begin
          tgt[cur_ch]   <= cur_t;
          drive[cur_ch] <= step_v;
        end
        KIND_TICK: begin
          if (!tick_idle) drive[cur_ch] <= step_v;
        end
        default: ;
      endcase
    end
  end

  // Queue control: pop in the load cycle, requeue at finish
  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      count  <= '0;
      queued <= '0;
    end else if (pop) begin
      head               <= head_inc;
      count              <= count - 1'b1;
      queued[fifo[head]] <= 1'b0;
    end else if (push) begin
      count          <= count + 1'b1;
      queued[cur_ch] <= 1'b1;
    end
  end

  // Queue entries hold no reset value
  always_ff @(posedge clk) begin
    if (push) fifo[tail] <= cur_ch;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if ((item.kind == KIND_TICK) && tick_idle) begin
        result.out_channel <= '0;
        result.out_value   <= '0;
        result.reached     <= 1'b0;
        result.idle        <= 1'b1;
      end else if (item.kind == KIND_CONFIG) begin
        result.out_channel <= CH_W'(cur_ch);
        result.out_value   <= mid;
        result.reached     <= 1'b1;
        result.idle        <= 1'b0;
      end else begin
        result.out_channel <= CH_W'(cur_ch);
        result.out_value   <= step_v;
        result.reached     <= done;
        result.idle        <= 1'b0;
      end
    end
  end

endmodule

>>> src/mcrs_ctrl.sv
// Controller: sequences capture, load, step-size math and writeback per item.
// Depends on mcrs_pkg; commands mcrs_dp and owns the result valid flag.
`timescale 1ns / 1ps

module mcrs_ctrl import mcrs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  output logic    result_valid,
  input  logic    result_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LOAD   = 5'b00010,
    ST_MUL    = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign item_stall = (state != ST_IDLE);
  assign out_free   = !result_valid || !result_stall;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (status.drop) begin
          state_next = ST_IDLE;
        end else begin
          cmd.load   = 1'b1;
          state_next = status.is_config ? ST_MUL : ST_FINISH;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div    = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Result valid: set on writeback, cleared when the transaction completes
  always_ff @(posedge clk) begin
    if (rst)               result_valid <= 1'b0;
    else if (cmd.finish)   result_valid <= 1'b1;
    else if (!result_stall) result_valid <= 1'b0;
  end

endmodule

>>> src/multi_channel_ramp_scheduler.sv
// Multi-channel ramp scheduler, one item at a time. Set-target and tick items: result
// valid 2 cycles after acceptance, next item taken 3 cycles after the previous;
// configure items: result after 4, next item after 5 (span multiply and reciprocal
// divide-by-100 stages); ignored items 2. A result waits in an output register while the
// next item is accepted; a second finished item waits for it. Synchronous reset restores
// register defaults, zeroes all channel records and empties the queue at once.
`timescale 1ns / 1ps

module multi_channel_ramp_scheduler import mcrs_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  mcrs_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  mcrs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  mcrs_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .cfg     (cfg),
    .item_in (item),
    .status  (status),
    .result  (result)
  );

endmodule
